/* sv/matrix_multiply_core_macros.svh */
// Assertion macros for the matrix multiply core.
// Used by the controller and datapath; no other dependencies.
`ifndef MATRIX_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MMC_ASSERT_NOW(label, clk, rst, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("mmc assertion failed");

// next-cycle implication
`define MMC_ASSERT_NEXT(label, clk, rst, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("mmc assertion failed");

`else

`define MMC_ASSERT_NOW(label, clk, rst, ant, cons)
`define MMC_ASSERT_NEXT(label, clk, rst, ant, cons)

`endif

`endif

/* sv/mmc_pkg.sv */
// Shared constants, types and helpers for the matrix multiply core.
// No dependencies; used by mmc_ctrl, mmc_datapath and the top level.
package mmc_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DIM_W   = 4;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = 40;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  // controller -> datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic             first;
    logic             end_dot;
    logic             last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } mmc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic en;
    logic busy;
  } mmc_stat_t;

  // last loop index for a dimension register: 0 acts as 1, above MAX_DIM as MAX_DIM
  function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] v;
    v = dim;
    if (v == '0) v = DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) v = DIM_W'(MAX_DIM);
    return IDX_W'(v - DIM_W'(1));
  endfunction

endpackage

/* sv/matrix_multiply_core.sv */
// Top level of the matrix multiply core: controller plus datapath.
// Depends on mmc_pkg, mmc_ctrl and mmc_datapath.
//
//   channel   handshake               payload
//   input     in_valid / in_stall     command, row_index, col_index, element_value
//   output    out_valid / out_stall   result_row, result_col, result_value, last_result
//   config    cfg_write               cfg_index, cfg_data
//
// Loads (write A, write B) and ignored commands are accepted back to back while idle.
// A compute holds in_stall while the single multiply-accumulate unit works through all
// rows*cols*inner products, reading one element from each store per product, and then
// while the last product passes the read registers, multiplier and accumulator into the
// output register, is taken by the output and the controller returns to idle. Output
// stall freezes the whole MAC pipeline and so lengthens the compute.
// Reset clears control state and sets all dimensions to 8; the stores are not cleared.
module matrix_multiply_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmc_pkg::DIM_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mmc_pkg::CMD_W-1:0]         command,
  input  logic [mmc_pkg::IDX_W-1:0]         row_index,
  input  logic [mmc_pkg::IDX_W-1:0]         col_index,
  input  logic signed [mmc_pkg::ELEM_W-1:0] element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mmc_pkg::IDX_W-1:0]         result_row,
  output logic [mmc_pkg::IDX_W-1:0]         result_col,
  output logic signed [mmc_pkg::ACC_W-1:0]  result_value,
  output logic                              last_result
);

  mmc_pkg::mmc_cmd_t  cmd;
  mmc_pkg::mmc_stat_t stat;

  mmc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .cmd        (cmd),
    .stat       (stat)
  );

  mmc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .row_index     (row_index),
    .col_index     (col_index),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_row    (result_row),
    .result_col    (result_col),
    .result_value  (result_value),
    .last_result   (last_result)
  );

endmodule

/* sv/mmc_datapath.sv */
// Datapath: A and B element stores, read registers, multiplier, accumulator
// and output register. Depends on mmc_pkg and the assertion macro header.
`include "matrix_multiply_core_macros.svh"

module mmc_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  mmc_pkg::mmc_cmd_t                 cmd,
  output mmc_pkg::mmc_stat_t                stat,
  input  logic [mmc_pkg::IDX_W-1:0]         row_index,
  input  logic [mmc_pkg::IDX_W-1:0]         col_index,
  input  logic signed [mmc_pkg::ELEM_W-1:0] element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mmc_pkg::IDX_W-1:0]         result_row,
  output logic [mmc_pkg::IDX_W-1:0]         result_col,
  output logic signed [mmc_pkg::ACC_W-1:0]  result_value,
  output logic                              last_result
);

  logic [mmc_pkg::ELEM_W-1:0] a_mem [mmc_pkg::DEPTH];
  logic [mmc_pkg::ELEM_W-1:0] b_mem [mmc_pkg::DEPTH];

  logic                              en;
  logic [mmc_pkg::ADDR_W-1:0]        wr_addr;
  logic [mmc_pkg::ADDR_W-1:0]        rd_a_addr;
  logic [mmc_pkg::ADDR_W-1:0]        rd_b_addr;

  logic                              s1_valid, s1_first, s1_end, s1_last;
  logic [mmc_pkg::IDX_W-1:0]         s1_i, s1_j;
  logic signed [mmc_pkg::ELEM_W-1:0] a_q, b_q;

  logic                              s2_valid, s2_first, s2_end, s2_last;
  logic [mmc_pkg::IDX_W-1:0]         s2_i, s2_j;
  logic signed [mmc_pkg::PROD_W-1:0] prod;

  logic signed [mmc_pkg::ACC_W-1:0]  acc;
  logic signed [mmc_pkg::ACC_W-1:0]  prod_ext;
  logic signed [mmc_pkg::ACC_W-1:0]  acc_next;

  // whole pipeline holds while a result waits on the output
  assign en        = !out_valid || !out_stall;
  assign stat.en   = en;
  assign stat.busy = s1_valid || s2_valid || out_valid;

  assign wr_addr   = {row_index, col_index};
  assign rd_a_addr = {cmd.i, cmd.k};
  assign rd_b_addr = {cmd.k, cmd.j};

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      a_mem[wr_addr] <= element_value;
    end
    if (cmd.wr_b) begin
      b_mem[wr_addr] <= element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q <= a_mem[rd_a_addr];
      b_q <= b_mem[rd_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      out_valid <= s2_valid && s2_end;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_first <= cmd.first;
      s1_end   <= cmd.end_dot;
      s1_last  <= cmd.last;
      s1_i     <= cmd.i;
      s1_j     <= cmd.j;
      s2_first <= s1_first;
      s2_end   <= s1_end;
      s2_last  <= s1_last;
      s2_i     <= s1_i;
      s2_j     <= s1_j;
      prod     <= a_q * b_q;
    end
  end

  assign prod_ext = {{(mmc_pkg::ACC_W - mmc_pkg::PROD_W){prod[mmc_pkg::PROD_W-1]}}, prod};
  assign acc_next = s2_first ? prod_ext : acc + prod_ext;

  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      acc <= acc_next;
      if (s2_end) begin
        result_value <= acc_next;
        result_row   <= s2_i;
        result_col   <= s2_j;
        last_result  <= s2_last;
      end
    end
  end

  `MMC_ASSERT_NEXT(a_end_loads_out, clk, rst, en && s2_valid && s2_end, out_valid)
  `MMC_ASSERT_NOW(a_last_drained, clk, rst, out_valid && last_result, !s1_valid && !s2_valid)

endmodule

/* sv/mmc_ctrl.sv */
// Controller: dimension registers, input handshake and the i/j/k sequencer
// that drives the datapath. Depends on mmc_pkg and the assertion macro header.
`include "matrix_multiply_core_macros.svh"

module mmc_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mmc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mmc_pkg::DIM_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mmc_pkg::CMD_W-1:0]            command,
  output mmc_pkg::mmc_cmd_t                    cmd,
  input  mmc_pkg::mmc_stat_t                   stat
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state, state_next;

  logic [mmc_pkg::DIM_W-1:0] rows_a, inner_size, cols_b;
  logic [mmc_pkg::IDX_W-1:0] m_last, n_last, p_last;
  logic [mmc_pkg::IDX_W-1:0] i_cnt, j_cnt, k_cnt;
  logic                      accept;
  logic                      k_wrap, j_wrap, i_wrap;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= mmc_pkg::DIM_RESET;
      inner_size <= mmc_pkg::DIM_RESET;
      cols_b     <= mmc_pkg::DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mmc_pkg::REG_ROWS_A:     rows_a     <= cfg_data;
        mmc_pkg::REG_INNER_SIZE: inner_size <= cfg_data;
        mmc_pkg::REG_COLS_B:     cols_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign k_wrap = (k_cnt == n_last);
  assign j_wrap = (j_cnt == p_last);
  assign i_wrap = (i_cnt == m_last);

  always_comb begin
    cmd         = '0;
    cmd.wr_a    = accept && (command == mmc_pkg::CMD_WRITE_A);
    cmd.wr_b    = accept && (command == mmc_pkg::CMD_WRITE_B);
    cmd.issue   = (state == ST_RUN) && stat.en;
    cmd.first   = (k_cnt == '0);
    cmd.end_dot = k_wrap;
    cmd.last    = k_wrap && j_wrap && i_wrap;
    cmd.i       = i_cnt;
    cmd.j       = j_cnt;
    cmd.k       = k_cnt;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && command == mmc_pkg::CMD_COMPUTE) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.issue && cmd.last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // dimensions are frozen at the compute transaction
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      m_last <= mmc_pkg::last_index(rows_a);
      n_last <= mmc_pkg::last_index(inner_size);
      p_last <= mmc_pkg::last_index(cols_b);
      i_cnt  <= '0;
      j_cnt  <= '0;
      k_cnt  <= '0;
    end else if (cmd.issue) begin
      if (k_wrap) begin
        k_cnt <= '0;
        if (j_wrap) begin
          j_cnt <= '0;
          i_cnt <= i_cnt + 1'b1;
        end else begin
          j_cnt <= j_cnt + 1'b1;
        end
      end else begin
        k_cnt <= k_cnt + 1'b1;
      end
    end
  end

  `MMC_ASSERT_NOW(a_cnt_in_range, clk, rst, state == ST_RUN,
                  k_cnt <= n_last && j_cnt <= p_last && i_cnt <= m_last)
  `MMC_ASSERT_NEXT(a_drain_done, clk, rst, state == ST_DRAIN && !stat.busy,
                   state == ST_IDLE)

endmodule
